// ----- sv/atp_pkg.sv -----
// ----------------------------------------------------------------------------
// atp_pkg
// Shared types and constants of the address text parser.
// ----------------------------------------------------------------------------
package atp_pkg;

  localparam int MAX_ADDR_BYTES_DEF = 64;
  localparam int CNT_W              = 8;
  localparam int LEN_W              = 7;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_BIG = 2'd2
  } status_e;

  typedef struct packed {
    logic       is_space;
    logic       is_text;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_dot;
    logic       is_colon;
    logic       is_dollar;
  } char_class_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [1:0] chunk_number;
    logic       done_res;
    status_e    status;
    logic       has_parent;
    len_t       parent_prefix_length;
    len_t       parent_id_length;
    len_t       prefix_length;
    len_t       id_length;
  } result_t;

endpackage

// ----- sv/address_text_parser_unit.sv -----
// A character goes through the input register and then the result register.
// Throughput: one character per cycle; the input register and the result register
// decouple the two channels, so input is stalled only while a held result is stalled.
// Characters that complete no byte and are not last give no result beat.
// Reset: asynchronous, active low; parser returns to start of string, registers empty.
// ----------------------------------------------------------------------------
// address_text_parser_unit
// Streaming address text parser: input register, parse core, result register.
// ----------------------------------------------------------------------------
module address_text_parser_unit #(
  parameter int MAX_ADDR_BYTES = atp_pkg::MAX_ADDR_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] character_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       byte_valid_o,
  output logic [7:0] data_byte_o,
  output logic [1:0] chunk_number_o,
  output logic       done_res_o,
  output logic [1:0] status_o,
  output logic       has_parent_o,
  output logic [6:0] parent_prefix_length_o,
  output logic [6:0] parent_id_length_o,
  output logic [6:0] prefix_length_o,
  output logic [6:0] id_length_o
);

  logic             in_valid_q;
  logic [7:0]       char_q;
  logic             last_q;
  logic             step;
  logic             produce;
  logic             out_free;
  logic             out_valid_q;
  atp_pkg::result_t res_d, res_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      char_q <= character_i;
      last_q <= last_char_i;
    end
  end

  atp_parse_core #(
    .MAX_ADDR_BYTES (MAX_ADDR_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .character_i (char_q),
    .last_char_i (last_q),
    .produce_o   (produce),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && produce) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign byte_valid_o           = res_q.byte_valid;
  assign data_byte_o            = res_q.data_byte;
  assign chunk_number_o         = res_q.chunk_number;
  assign done_res_o             = res_q.done_res;
  assign status_o               = res_q.status;
  assign has_parent_o           = res_q.has_parent;
  assign parent_prefix_length_o = res_q.parent_prefix_length;
  assign parent_id_length_o     = res_q.parent_id_length;
  assign prefix_length_o        = res_q.prefix_length;
  assign id_length_o            = res_q.id_length;

endmodule

// ----- sv/atp_char_class.sv -----
// ----------------------------------------------------------------------------
// atp_char_class
// Classifies one text character: whitespace, text, hex digit, separators.
// ----------------------------------------------------------------------------
module atp_char_class (
  input  logic [7:0]                character_i,
  output atp_pkg::char_class_t      class_o
);

  always_comb begin
    class_o           = '0;
    class_o.is_space  = (character_i == atp_pkg::CH_SPACE) ||
                        (character_i >= atp_pkg::CH_TAB && character_i <= atp_pkg::CH_CR);
    class_o.is_dot    = (character_i == atp_pkg::CH_DOT);
    class_o.is_colon  = (character_i == atp_pkg::CH_COLON);
    class_o.is_dollar = (character_i == atp_pkg::CH_DOLLAR);
    class_o.is_text   = (character_i > atp_pkg::CH_SPACE) &&
                        (character_i <= atp_pkg::CH_TILDE) &&
                        (character_i != atp_pkg::CH_COLON) &&
                        (character_i != atp_pkg::CH_SLASH) &&
                        (character_i != atp_pkg::CH_DOT) &&
                        (character_i != atp_pkg::CH_DOLLAR);
    if (character_i >= 8'h30 && character_i <= 8'h39) begin
      class_o.is_hex  = 1'b1;
      class_o.hex_val = character_i[3:0];
    end else if ((character_i >= 8'h61 && character_i <= 8'h66) ||
                 (character_i >= 8'h41 && character_i <= 8'h46)) begin
      class_o.is_hex  = 1'b1;
      class_o.hex_val = 4'(character_i[2:0] + 3'd1) + 4'd8;
    end
  end

endmodule

// ----- sv/atp_parse_core.sv -----
// ----------------------------------------------------------------------------
// atp_parse_core
// Parser state and per-character update; produces at most one result a beat.
// ----------------------------------------------------------------------------
module atp_parse_core #(
  parameter int MAX_ADDR_BYTES = atp_pkg::MAX_ADDR_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            character_i,
  input  logic                  last_char_i,
  output logic                  produce_o,
  output atp_pkg::result_t      result_o
);

  atp_pkg::char_class_t cls;

  logic             start_q,  start_d;
  logic             hex_q,    hex_d;
  logic [1:0]       dot_q,    dot_d;
  logic             colon_q,  colon_d;
  logic [3:0]       hnib_q,   hnib_d;
  logic             pend_q,   pend_d;
  logic             tspace_q, tspace_d;
  logic [1:0]       cnt_q,    cnt_d;
  atp_pkg::cnt_t    len_q [4];
  atp_pkg::cnt_t    len_d [4];
  atp_pkg::cnt_t    total_q,  total_d;
  atp_pkg::status_e err_q,    err_d;

  atp_char_class u_class (
    .character_i (character_i),
    .class_o     (cls)
  );

  always_comb begin
    logic             emit;
    logic [7:0]       byte_val;
    logic [1:0]       chunk;
    atp_pkg::status_e fin;

    start_d  = 1'b0;
    hex_d    = hex_q;
    dot_d    = dot_q;
    colon_d  = colon_q;
    hnib_d   = hnib_q;
    pend_d   = pend_q;
    tspace_d = tspace_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    total_d  = total_q;
    err_d    = err_q;
    emit     = 1'b0;
    byte_val = '0;
    chunk    = dot_q + {1'b0, colon_q};
    fin      = atp_pkg::ST_OK;
    result_o = '0;

    if (err_q == atp_pkg::ST_OK) begin
      if (cls.is_space) begin
        tspace_d = 1'b1;
      end else if (tspace_q) begin
        err_d = atp_pkg::ST_BAD;
      end else begin
        if (cnt_q < 2'd2) begin
          cnt_d = cnt_q + 2'd1;
        end
        if (start_q && cls.is_dollar) begin
          hex_d = 1'b1;
        end else if (cls.is_dot) begin
          if (dot_q >= 2'd2 || (dot_q == 2'd1 && !colon_q) || pend_q) begin
            err_d = atp_pkg::ST_BAD;
          end else begin
            dot_d = dot_q + 2'd1;
          end
        end else if (cls.is_colon) begin
          if (colon_q || dot_q == 2'd0 || pend_q) begin
            err_d = atp_pkg::ST_BAD;
          end else begin
            colon_d = 1'b1;
          end
        end else if (hex_q) begin
          if (!cls.is_hex) begin
            err_d = atp_pkg::ST_BAD;
          end else if (!pend_q) begin
            hnib_d = cls.hex_val;
            pend_d = 1'b1;
          end else begin
            pend_d   = 1'b0;
            emit     = 1'b1;
            byte_val = {hnib_q, cls.hex_val};
          end
        end else if (!cls.is_text) begin
          err_d = atp_pkg::ST_BAD;
        end else begin
          emit     = 1'b1;
          byte_val = character_i;
        end
        if (emit) begin
          if (total_q >= atp_pkg::cnt_t'(MAX_ADDR_BYTES)) begin
            err_d = atp_pkg::ST_BIG;
            emit  = 1'b0;
          end else begin
            total_d      = total_q + 1'b1;
            len_d[chunk] = len_q[chunk] + 1'b1;
          end
        end
      end
    end

    fin = err_d;
    if (fin == atp_pkg::ST_OK &&
        (dot_d == 2'd0 || (colon_d && dot_d < 2'd2) || pend_d || cnt_d < 2'd2)) begin
      fin = atp_pkg::ST_BAD;
    end

    if (emit) begin
      result_o.byte_valid   = 1'b1;
      result_o.data_byte    = byte_val;
      result_o.chunk_number = chunk;
    end
    if (last_char_i) begin
      result_o.done_res = 1'b1;
      result_o.status   = fin;
      if (fin == atp_pkg::ST_OK) begin
        if (colon_d) begin
          result_o.has_parent           = 1'b1;
          result_o.parent_prefix_length = len_d[0][atp_pkg::LEN_W-1:0];
          result_o.parent_id_length     = len_d[1][atp_pkg::LEN_W-1:0];
          result_o.prefix_length        = len_d[2][atp_pkg::LEN_W-1:0];
          result_o.id_length            = len_d[3][atp_pkg::LEN_W-1:0];
        end else begin
          result_o.prefix_length = len_d[0][atp_pkg::LEN_W-1:0];
          result_o.id_length     = len_d[1][atp_pkg::LEN_W-1:0];
        end
      end
      start_d  = 1'b1;
      hex_d    = 1'b0;
      dot_d    = '0;
      colon_d  = 1'b0;
      hnib_d   = '0;
      pend_d   = 1'b0;
      tspace_d = 1'b0;
      cnt_d    = '0;
      total_d  = '0;
      err_d    = atp_pkg::ST_OK;
      for (int i = 0; i < 4; i++) begin
        len_d[i] = '0;
      end
    end
    produce_o = emit || last_char_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= 1'b1;
      hex_q    <= 1'b0;
      dot_q    <= '0;
      colon_q  <= 1'b0;
      hnib_q   <= '0;
      pend_q   <= 1'b0;
      tspace_q <= 1'b0;
      cnt_q    <= '0;
      total_q  <= '0;
      err_q    <= atp_pkg::ST_OK;
      for (int i = 0; i < 4; i++) begin
        len_q[i] <= '0;
      end
    end else if (step_i) begin
      start_q  <= start_d;
      hex_q    <= hex_d;
      dot_q    <= dot_d;
      colon_q  <= colon_d;
      hnib_q   <= hnib_d;
      pend_q   <= pend_d;
      tspace_q <= tspace_d;
      cnt_q    <= cnt_d;
      total_q  <= total_d;
      err_q    <= err_d;
      len_q    <= len_d;
    end
  end

endmodule

// ----- sv/atp_checker.sv -----
// ----------------------------------------------------------------------------
// atp_checker
// Port-level checks of the address text parser result channel.
// ----------------------------------------------------------------------------
module atp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       byte_valid_o,
  input logic [7:0] data_byte_o,
  input logic [1:0] chunk_number_o,
  input logic       done_res_o,
  input logic [1:0] status_o,
  input logic       has_parent_o,
  input logic [6:0] parent_prefix_length_o,
  input logic [6:0] parent_id_length_o,
  input logic [6:0] prefix_length_o,
  input logic [6:0] id_length_o
);

  a_valid_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_payload_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(data_byte_o) && $stable(done_res_o) &&
      $stable(status_o) && $stable(byte_valid_o))
    else $error("stalled result changed");

  a_beat_content : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_valid_o || done_res_o) &&
      (byte_valid_o || (data_byte_o == 8'd0 && chunk_number_o == 2'd0)))
    else $error("empty result beat or stray byte fields");

  a_status_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !done_res_o |-> status_o == 2'd0 && !has_parent_o &&
      prefix_length_o == 7'd0 && id_length_o == 7'd0)
    else $error("status fields set before end of string");

  a_error_lengths : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o && status_o != 2'd0 |-> !has_parent_o &&
      parent_prefix_length_o == 7'd0 && parent_id_length_o == 7'd0 &&
      prefix_length_o == 7'd0 && id_length_o == 7'd0)
    else $error("lengths reported with error status");

endmodule

bind address_text_parser_unit atp_checker u_atp_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .out_valid_o            (out_valid_o),
  .out_stall_i            (out_stall_i),
  .byte_valid_o           (byte_valid_o),
  .data_byte_o            (data_byte_o),
  .chunk_number_o         (chunk_number_o),
  .done_res_o             (done_res_o),
  .status_o               (status_o),
  .has_parent_o           (has_parent_o),
  .parent_prefix_length_o (parent_prefix_length_o),
  .parent_id_length_o     (parent_id_length_o),
  .prefix_length_o        (prefix_length_o),
  .id_length_o            (id_length_o)
);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Regression bench for address_text_parser_unit: strings are streamed in one
// character per beat, each beat is run through a bench-side parser, and every
// result beat is compared field by field against what that parser predicts.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_CHARS = 400;

  typedef bit [7:0] text_q_t[$];

  class parse_scoreboard;
    atp_pkg::result_t parsed_q[$];
    int               errors;
    int               beats;
    int               n_status[3];
    bit               at_start;
    bit               hex_mode;
    bit [1:0]         dots;
    bit               colon;
    bit [3:0]         hi_nib;
    bit               nib_pend;
    bit               ws_seen;
    bit [1:0]         nonspace_cnt;
    int               chunk_len[4];
    int               total;
    atp_pkg::status_e err;

    function new();
      restart();
    endfunction

    function void restart();
      at_start     = 1'b1;
      hex_mode     = 1'b0;
      dots         = '0;
      colon        = 1'b0;
      hi_nib       = '0;
      nib_pend     = 1'b0;
      ws_seen      = 1'b0;
      nonspace_cnt = '0;
      chunk_len    = '{0, 0, 0, 0};
      total        = 0;
      err          = atp_pkg::ST_OK;
    endfunction

    function void note_error(atp_pkg::status_e s);
      if (err == atp_pkg::ST_OK) err = s;
    endfunction

    function void parse_char(bit [7:0] c, bit lst);
      atp_pkg::result_t r;
      bit      emit;
      bit      first;
      bit      ws;
      bit      txt;
      bit [1:0] chunk;
      bit [7:0] b;
      int      v;
      r     = '0;
      emit  = 1'b0;
      b     = '0;
      chunk = dots + colon;
      first = at_start;
      at_start = 1'b0;
      ws  = (c == atp_pkg::CH_SPACE) || (c >= atp_pkg::CH_TAB && c <= atp_pkg::CH_CR);
      txt = c > atp_pkg::CH_SPACE && c <= atp_pkg::CH_TILDE &&
            !(c inside {atp_pkg::CH_COLON, atp_pkg::CH_SLASH,
                        atp_pkg::CH_DOT, atp_pkg::CH_DOLLAR});
      if (err == atp_pkg::ST_OK) begin
        if (ws) begin
          ws_seen = 1'b1;
        end else if (ws_seen) begin
          note_error(atp_pkg::ST_BAD);
        end else begin
          if (nonspace_cnt < 2) nonspace_cnt++;
          if (first && c == atp_pkg::CH_DOLLAR) begin
            hex_mode = 1'b1;
          end else if (c == atp_pkg::CH_DOT) begin
            if (dots >= 2 || (dots == 1 && !colon) || nib_pend) note_error(atp_pkg::ST_BAD);
            else dots++;
          end else if (c == atp_pkg::CH_COLON) begin
            if (colon || dots == 0 || nib_pend) note_error(atp_pkg::ST_BAD);
            else colon = 1'b1;
          end else if (hex_mode) begin
            if (c >= "0" && c <= "9") v = int'(c - "0");
            else if (c >= "a" && c <= "f") v = int'(c - "a") + 10;
            else if (c >= "A" && c <= "F") v = int'(c - "A") + 10;
            else v = 16;
            if (v > 15) begin
              note_error(atp_pkg::ST_BAD);
            end else if (!nib_pend) begin
              hi_nib   = v[3:0];
              nib_pend = 1'b1;
            end else begin
              nib_pend = 1'b0;
              emit     = 1'b1;
              b        = {hi_nib, v[3:0]};
            end
          end else if (!txt) begin
            note_error(atp_pkg::ST_BAD);
          end else begin
            emit = 1'b1;
            b    = c;
          end
          if (emit) begin
            if (total >= atp_pkg::MAX_ADDR_BYTES_DEF) begin
              note_error(atp_pkg::ST_BIG);
              emit = 1'b0;
            end else begin
              total++;
              chunk_len[chunk]++;
            end
          end
        end
      end
      if (!emit && !lst) return;
      if (emit) begin
        r.byte_valid   = 1'b1;
        r.data_byte    = b;
        r.chunk_number = chunk;
      end
      if (lst) begin
        if (err == atp_pkg::ST_OK && (dots == 0 || (colon && dots < 2) || nib_pend ||
                                      nonspace_cnt < 2))
          note_error(atp_pkg::ST_BAD);
        r.done_res = 1'b1;
        r.status   = err;
        if (err == atp_pkg::ST_OK) begin
          if (colon) begin
            r.has_parent           = 1'b1;
            r.parent_prefix_length = atp_pkg::len_t'(chunk_len[0]);
            r.parent_id_length     = atp_pkg::len_t'(chunk_len[1]);
            r.prefix_length        = atp_pkg::len_t'(chunk_len[2]);
            r.id_length            = atp_pkg::len_t'(chunk_len[3]);
          end else begin
            r.prefix_length = atp_pkg::len_t'(chunk_len[0]);
            r.id_length     = atp_pkg::len_t'(chunk_len[1]);
          end
        end
        restart();
      end
      parsed_q.push_back(r);
    endfunction

    function void cmp(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_beat(atp_pkg::result_t got);
      atp_pkg::result_t want;
      if (parsed_q.size() == 0) begin
        $error("result beat with nothing pending: byte_valid %0b done_res %0b",
               got.byte_valid, got.done_res);
        errors++;
        return;
      end
      want = parsed_q.pop_front();
      beats++;
      if (want.done_res) n_status[want.status]++;
      cmp("byte_valid", want.byte_valid, got.byte_valid);
      cmp("data_byte", want.data_byte, got.data_byte);
      cmp("chunk_number", want.chunk_number, got.chunk_number);
      cmp("done_res", want.done_res, got.done_res);
      cmp("status", want.status, got.status);
      cmp("has_parent", want.has_parent, got.has_parent);
      cmp("parent_prefix_length", want.parent_prefix_length, got.parent_prefix_length);
      cmp("parent_id_length", want.parent_id_length, got.parent_id_length);
      cmp("prefix_length", want.prefix_length, got.prefix_length);
      cmp("id_length", want.id_length, got.id_length);
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] character_i = '0;
  logic       last_char_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       byte_valid_o;
  logic [7:0] data_byte_o;
  logic [1:0] chunk_number_o;
  logic       done_res_o;
  logic [1:0] status_o;
  logic       has_parent_o;
  logic [6:0] parent_prefix_length_o;
  logic [6:0] parent_id_length_o;
  logic [6:0] prefix_length_o;
  logic [6:0] id_length_o;

  parse_scoreboard  sb = new();
  atp_pkg::result_t seen_beat;
  int      send_idle_pct = 0;
  int      stall_pct     = 0;
  int      chars_sent    = 0;
  int      strings_sent  = 0;
  int      cycles        = 0;

  address_text_parser_unit u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .character_i           (character_i),
    .last_char_i           (last_char_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .byte_valid_o          (byte_valid_o),
    .data_byte_o           (data_byte_o),
    .chunk_number_o        (chunk_number_o),
    .done_res_o            (done_res_o),
    .status_o              (status_o),
    .has_parent_o          (has_parent_o),
    .parent_prefix_length_o(parent_prefix_length_o),
    .parent_id_length_o    (parent_id_length_o),
    .prefix_length_o       (prefix_length_o),
    .id_length_o           (id_length_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("address_text_parser_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.parse_char(character_i, last_char_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_beat.byte_valid           = byte_valid_o;
      seen_beat.data_byte            = data_byte_o;
      seen_beat.chunk_number         = chunk_number_o;
      seen_beat.done_res             = done_res_o;
      seen_beat.status               = atp_pkg::status_e'(status_o);
      seen_beat.has_parent           = has_parent_o;
      seen_beat.parent_prefix_length = parent_prefix_length_o;
      seen_beat.parent_id_length     = parent_id_length_o;
      seen_beat.prefix_length        = prefix_length_o;
      seen_beat.id_length            = id_length_o;
      sb.check_beat(seen_beat);
    end
  end

  task automatic send_char(bit [7:0] c, bit lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    character_i <= c;
    last_char_i <= lst;
    do @(posedge clk_i); while (in_stall_o);
    chars_sent++;
  endtask

  task automatic send_bytes(text_q_t s);
    foreach (s[i]) send_char(s[i], i == s.size() - 1);
    strings_sent++;
  endtask

  task automatic send_text(string s);
    text_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_bytes(q);
  endtask

  function automatic bit [7:0] hex_digit_char(bit [3:0] d);
    if (d < 10) return "0" + d;
    return 8'(($urandom_range(1) ? "a" : "A") + d - 10);
  endfunction

  function automatic bit [7:0] odd_char();
    case ($urandom_range(6))
      0: return atp_pkg::CH_COLON;
      1: return atp_pkg::CH_DOT;
      2: return atp_pkg::CH_DOLLAR;
      3: return atp_pkg::CH_SPACE;
      4: return atp_pkg::CH_TAB;
      5: return atp_pkg::CH_SLASH;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic int chunk_size();
    int r;
    r = $urandom_range(99);
    if (r < 2) return $urandom_range(60, 70);
    if (r < 6) return $urandom_range(10, 40);
    return $urandom_range(0, 5);
  endfunction

  function automatic void add_chunk(ref text_q_t s, input bit hex, input int n);
    bit [7:0] c;
    for (int i = 0; i < n; i++) begin
      c = 8'($urandom_range(255));
      if (hex) begin
        s.push_back(hex_digit_char(c[7:4]));
        s.push_back(hex_digit_char(c[3:0]));
      end else begin
        do c = 8'($urandom_range(33, 126));
        while (c inside {atp_pkg::CH_COLON, atp_pkg::CH_SLASH,
                         atp_pkg::CH_DOT, atp_pkg::CH_DOLLAR});
        s.push_back(c);
      end
    end
  endfunction

  function automatic void build_random(ref text_q_t s);
    int kind;
    int pos;
    bit hex;
    kind = $urandom_range(99);
    s.delete();
    if (kind < 12) begin
      repeat ($urandom_range(1, 8))
        s.push_back($urandom_range(2) == 0 ? odd_char() : 8'($urandom_range(255)));
      return;
    end
    hex = ($urandom_range(99) < 35);
    if (hex) s.push_back(atp_pkg::CH_DOLLAR);
    add_chunk(s, hex, chunk_size());
    s.push_back(atp_pkg::CH_DOT);
    add_chunk(s, hex, chunk_size());
    if ($urandom_range(1)) begin
      s.push_back(atp_pkg::CH_COLON);
      add_chunk(s, hex, chunk_size());
      s.push_back(atp_pkg::CH_DOT);
      add_chunk(s, hex, chunk_size());
    end
    if ($urandom_range(99) < 20)
      repeat ($urandom_range(1, 3))
        s.push_back($urandom_range(5) == 5 ? atp_pkg::CH_SPACE : 8'($urandom_range(9, 13)));
    if (kind < 27) begin
      pos = $urandom_range(0, s.size() - 1);
      case ($urandom_range(2))
        0: s[pos] = odd_char();
        1: s.insert(pos, odd_char());
        default: if (s.size() > 1) s.delete(pos);
      endcase
    end
  endfunction

  initial begin
    string   dir_list[$];
    string   run;
    text_q_t s;
    int      start;
    dir_list = '{"ab.cd", "p.q:r.s", "$00.ff", "$0a1B.c2:D3.e4", "!~.~!", "$.", "a.",
                 "abc", ".", "$abc.de", "a.b:c", ":a.b", "a.b.c", "a.b:c.d:e",
                 "a.b:c.d.e", "a.b \t\n\r", "a .b", " a.b", "a\177.b", "a/.b",
                 "a.$b", "$0g.00", "  ", "a.b:", "$0:1.2"};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_list[i]) send_text(dir_list[i]);
    run = "";
    repeat (63) run = {run, "x"};
    send_text({run, ".y"});
    send_text({run, "xx.y"});

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      start = chars_sent;
      while (chars_sent - start < PHASE_CHARS) begin
        build_random(s);
        send_bytes(s);
      end
    end
    in_valid_i <= 1'b0;

    while (sb.parsed_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("streamed %0d strings (%0d characters) under four idle/stall mixes",
             strings_sent, chars_sent);
    $display("checked %0d result beats; strings closed ok %0d, malformed %0d, over capacity %0d",
             sb.beats, sb.n_status[atp_pkg::ST_OK], sb.n_status[atp_pkg::ST_BAD],
             sb.n_status[atp_pkg::ST_BIG]);
    if (sb.errors == 0) begin
      $display("address_text_parser_unit regression: pass");
    end else begin
      $display("address_text_parser_unit regression: fail");
    end
    $finish;
  end

endmodule
